/* hw/rtl/shash_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Round constants, initial hash values, state encoding and the SHA-256
// rotate and sigma functions.
// ----------------------------------------------------------------------------
package shash_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumHash   = 8;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:0] KindByte   = 1'b0;
  localparam logic [0:0] KindFinish = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FOLD  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [31:0] r;
    r = (x >> n) | (x << (32 - n));
    return r;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* hw/rtl/sha256_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// Timing: a byte transfer completes while idle; the 64th byte of a block starts
// 64 rounds of the shared round unit plus one fold of the chaining words.
// Finish: one padded block or two are compressed, then 8 digest transfers follow.
// Input stalls while a block is compressed or the digest is out; rounds run one per cycle.
// Reset: asynchronous, active low; chaining words return to the initial hash
// values, fill count and bit length to zero. The same happens after each digest.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Collects message bytes into a 16-word schedule window, runs the compression
// one round per cycle and emits the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  kind_i,
  input  logic [7:0]  msg_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import shash_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  idx_q, idx_d;
  logic        finish_q, finish_d;
  logic        second_q, second_d;
  logic [31:0] h_q [NumHash];
  logic [31:0] h_d [NumHash];
  logic [31:0] s_q [NumHash];
  logic [31:0] s_d [NumHash];
  logic [31:0] w_q [NumWords];
  logic [31:0] w_d [NumWords];

  logic [31:0] hsum [NumHash];
  logic [31:0] pad_w [NumWords];
  logic [31:0] t1, t2, ch, maj, w_new;
  logic        in_xfer, out_xfer;
  logic [5:0]  pos;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_xfer       = in_valid_i && !in_stall_o;
  assign out_valid_o   = (state_q == ST_OUT);
  assign out_xfer      = out_valid_o && !out_stall_i;
  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  always_comb begin
    ch    = (s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6]);
    maj   = (s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]);
    t1    = s_q[7] + big_sigma1(s_q[4]) + ch + RoundK[round_q] + w_q[0];
    t2    = big_sigma0(s_q[0]) + maj;
    w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
    for (int i = 0; i < NumHash; i++) begin
      hsum[i] = h_q[i] + s_q[i];
    end
  end

  // Pad a copy of the partial block: bytes below the fill count, 0x80, zeros, and the length if it fits.
  always_comb begin
    for (int j = 0; j < NumWords; j++) begin
      for (int b = 0; b < 4; b++) begin
        pos = {4'(j), 2'(b)};
        if (pos < fill_q) begin
          pad_w[j][31-8*b -: 8] = w_q[j][31-8*b -: 8];
        end else if (pos == fill_q) begin
          pad_w[j][31-8*b -: 8] = PadByte;
        end else begin
          pad_w[j][31-8*b -: 8] = 8'h00;
        end
      end
    end
    if (fill_q < 6'd56) begin
      pad_w[14] = len_q[63:32];
      pad_w[15] = len_q[31:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    len_d    = len_q;
    round_d  = round_q;
    idx_d    = idx_q;
    finish_d = finish_q;
    second_d = second_q;
    h_d      = h_q;
    s_d      = s_q;
    w_d      = w_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          s_d     = h_q;
          round_d = '0;
          if (kind_i == KindFinish) begin
            w_d      = pad_w;
            second_d = (fill_q >= 6'd56);
            finish_d = 1'b1;
            state_d  = ST_ROUND;
          end else begin
            w_d[fill_q[5:2]][31-8*fill_q[1:0] -: 8] = msg_byte_i;
            fill_d = fill_q + 6'd1;
            len_d  = len_q + 64'd8;
            if (fill_q == 6'd63) begin
              state_d = ST_ROUND;
            end
          end
        end
      end
      ST_ROUND: begin
        s_d[7] = s_q[6];
        s_d[6] = s_q[5];
        s_d[5] = s_q[4];
        s_d[4] = s_q[3] + t1;
        s_d[3] = s_q[2];
        s_d[2] = s_q[1];
        s_d[1] = s_q[0];
        s_d[0] = t1 + t2;
        for (int i = 0; i < NumWords - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[NumWords-1] = w_new;
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        h_d = hsum;
        if (!finish_q) begin
          state_d = ST_IDLE;
        end else if (second_q) begin
          for (int i = 0; i < NumWords; i++) begin
            w_d[i] = '0;
          end
          w_d[14]  = len_q[63:32];
          w_d[15]  = len_q[31:0];
          s_d      = hsum;
          round_d  = '0;
          second_d = 1'b0;
          state_d  = ST_ROUND;
        end else begin
          idx_d   = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            h_d      = InitH;
            fill_d   = '0;
            len_d    = '0;
            finish_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      len_q    <= '0;
      round_q  <= '0;
      idx_q    <= '0;
      finish_q <= 1'b0;
      second_q <= 1'b0;
      h_q      <= InitH;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      len_q    <= len_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
      finish_q <= finish_d;
      second_q <= second_d;
      h_q      <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    w_q <= w_d;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte and finish transfers with random gaps and output stalls. Digests
// come from a bit-accurate SHA-256 model kept inside the bench, or from known
// vectors for the empty message and "abc". Each digest word is compared in
// order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import shash_pkg::KindByte;
  import shash_pkg::KindFinish;

  localparam int NumDirected  = 12;
  localparam int StuckLimit   = 2000;
  localparam int DrainCycles  = 200;
  localparam int MaxReports   = 10;
  localparam logic [7:0] PadMarker = 8'h80;

  localparam logic [255:0] EmptyDigest =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [31:0] IvH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam int BoundaryLens [3] = '{55, 56, 64};

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last_word;
  } digest_xfer_t;

  typedef struct packed {
    logic [0:0]   kind;
    logic [7:0]   msg_byte;
    logic         pinned;
    logic [255:0] digest;
  } stim_row_t;

  stim_row_t directed_rows [NumDirected] = '{
    '{KindFinish, 8'h00, 1'b1, EmptyDigest},
    '{KindByte,   8'h61, 1'b0, 256'h0},
    '{KindByte,   8'h62, 1'b0, 256'h0},
    '{KindByte,   8'h63, 1'b0, 256'h0},
    '{KindFinish, 8'h00, 1'b1, AbcDigest},
    '{KindFinish, 8'hff, 1'b1, EmptyDigest},
    '{KindByte,   8'h00, 1'b0, 256'h0},
    '{KindByte,   8'hff, 1'b0, 256'h0},
    '{KindByte,   8'h80, 1'b0, 256'h0},
    '{KindFinish, 8'h5a, 1'b0, 256'h0},
    '{KindByte,   8'hff, 1'b0, 256'h0},
    '{KindFinish, 8'h00, 1'b0, 256'h0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [0:0]  kind_i      = KindByte;
  logic [7:0]  msg_byte_i  = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_stream_hasher_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .msg_byte_i   (msg_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0]  hash_h [8];
  logic [511:0] msg_block;
  int           fill_cnt;
  logic [63:0]  bit_len;

  digest_xfer_t digest_q [$];
  bit   tx_gapless = 1'b0;
  bit   rx_eager   = 1'b0;
  int   items_sent = 0;
  int   messages   = 0;
  int   longest    = 0;
  int   two_block_pads = 0;
  int   words_checked  = 0;
  int   mismatches = 0;
  int   stuck      = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic void restart_hash();
    hash_h    = IvH;
    msg_block = '0;
    fill_cnt  = 0;
    bit_len   = '0;
  endfunction

  function automatic void sha_fold(input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i - 16] + w[i - 7]
           + (ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3))
           + (ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10));
    end
    {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundConst[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
    hash_h[5] += f;
    hash_h[6] += g;
    hash_h[7] += h;
  endfunction

  // Advance the hash state by one transfer; a finish yields the digest.
  function automatic void absorb_item(input logic [0:0] kind, input logic [7:0] b,
                                      output logic finished, output logic [255:0] digest);
    logic [1023:0] pad;
    int n;
    finished = 1'b0;
    digest   = '0;
    if (kind == KindByte) begin
      msg_block[511 - 8 * fill_cnt -: 8] = b;
      fill_cnt++;
      bit_len += 64'd8;
      if (fill_cnt == 64) begin
        sha_fold(msg_block);
        fill_cnt = 0;
      end
    end else begin
      n   = fill_cnt;
      pad = '0;
      for (int i = 0; i < n; i++) pad[1023 - 8 * i -: 8] = msg_block[511 - 8 * i -: 8];
      pad[1023 - 8 * n -: 8] = PadMarker;
      if (n < 56) begin
        pad[575:512] = bit_len;
        sha_fold(pad[1023:512]);
      end else begin
        pad[63:0] = bit_len;
        sha_fold(pad[1023:512]);
        sha_fold(pad[511:0]);
        two_block_pads++;
      end
      if (int'(bit_len >> 3) > longest) longest = int'(bit_len >> 3);
      messages++;
      digest = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
      finished = 1'b1;
      restart_hash();
    end
  endfunction

  task automatic send_item(input logic [0:0] kind, input logic [7:0] b,
                           input logic pinned, input logic [255:0] pinned_digest);
    int gap;
    logic done;
    logic [255:0] dg;
    digest_xfer_t x;
    gap = tx_gapless ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    msg_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    absorb_item(kind, b, done, dg);
    if (done) begin
      if (pinned) dg = pinned_digest;
      for (int k = 0; k < 8; k++) begin
        x.word      = dg[255 - 32 * k -: 32];
        x.index     = 3'(k);
        x.last_word = (k == 7);
        digest_q.push_back(x);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input digest_xfer_t want,
                               input digest_xfer_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("tb_top: %s at %0t: expected word %h index %0d last %b, got %h index %0d last %b",
               what, $time, want.word, want.index, want.last_word,
               got.word, got.index, got.last_word);
    end
  endtask

  always @(posedge clk_i) begin : digest_check
    digest_xfer_t got;
    digest_xfer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{digest_word_o, word_index_o, last_word_o};
      words_checked++;
      if (digest_q.size() == 0) begin
        note_mismatch("unexpected digest word", '0, got);
      end else begin
        want = digest_q.pop_front();
        if (got !== want) note_mismatch("digest word mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck <= 0;
    end else if (stuck + 1 >= StuckLimit) begin
      $display("tb_top: no transfer for %0d cycles, %0d digest words still due",
               StuckLimit, digest_q.size());
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin : drain_side
    int hold;
    forever begin
      hold = rx_eager ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int len;
    int m;
    restart_hash();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].kind, directed_rows[i].msg_byte,
                directed_rows[i].pinned, directed_rows[i].digest);
    end

    // hold off until every digest word is out
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);

    m = 0;
    while (m < 10 || items_sent < NumDirected + 200) begin
      if (m < 3) len = BoundaryLens[m];
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(56, 70);
      else len = $urandom_range(0, 12);
      tx_gapless = ($urandom_range(0, 3) == 0);
      rx_eager   = ($urandom_range(0, 3) == 0);
      repeat (len) send_item(KindByte, 8'($urandom_range(0, 255)), 1'b0, '0);
      send_item(KindFinish, 8'($urandom_range(0, 255)), 1'b0, '0);
      m++;
    end
    in_valid_i <= 1'b0;
    rx_eager   = 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb_top: %0d transfers in, %0d messages, longest %0d bytes, %0d padded into two blocks",
             items_sent, messages, longest, two_block_pads);
    $display("tb_top: %0d digest words checked, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/shash_pkg.sv
hw/rtl/sha256_stream_hasher_unit.sv
tb/tb_top.sv
